### hw/rtl/tkvt_pkg.sv
package tkvt_pkg;

    // Default number of cells in the chain.
    localparam int TKVT_CAPACITY = 32;

    localparam int VALUE_W = 32;
    localparam int TAG_W   = 32;
    localparam int KEEP_W  = 6;
    localparam int HELD_W  = 6;
    localparam int KIND_W  = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_KEEP_COUNT = 1'b0;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd32;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] item_value;
        logic [TAG_W-1:0]   item_tag;
    } t_in_beat;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic               accepted;
        logic [HELD_W-1:0]  held_count;
        logic [VALUE_W-1:0] entry_value;
        logic [TAG_W-1:0]   entry_tag;
        logic               last;
    } t_out_beat;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // What every cell of the chain does in a cycle.
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_INSERT_EVICT,
        CM_SHIFT
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        t_entry     item;
    } t_cell_cmd;

endpackage

### hw/rtl/tkvt_cell.sv
module tkvt_cell (
    input  logic               i_clk,
    input  tkvt_pkg::t_cell_cmd i_cmd,
    input  logic               i_valid,
    input  tkvt_pkg::t_entry   i_prev_entry,
    input  logic               i_prev_below,
    input  tkvt_pkg::t_entry   i_next_entry,
    input  logic               i_next_below,
    output tkvt_pkg::t_entry   o_entry,
    output logic               o_below
);
    import tkvt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // This cell holds a value strictly below the offered one.
    assign o_below = i_valid && (r_entry.value < i_cmd.item.value);
    assign o_entry = r_entry;

    always_comb begin
        case (i_cmd.mode)
            CM_HOLD: begin
                n_entry = r_entry;
            end
            CM_INSERT: begin
                // Entries at or above the insert point move up by one.
                if (o_below) begin
                    n_entry = r_entry;
                end else if (i_prev_below) begin
                    n_entry = i_cmd.item;
                end else begin
                    n_entry = i_prev_entry;
                end
            end
            CM_INSERT_EVICT: begin
                // Entries below the insert point move down by one.
                if (i_next_below) begin
                    n_entry = i_next_entry;
                end else if (o_below) begin
                    n_entry = i_cmd.item;
                end else begin
                    n_entry = r_entry;
                end
            end
            CM_SHIFT: begin
                n_entry = i_next_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hw/rtl/top_k_value_tracker_core.sv
// Insert: the status beat is in the output register in the cycle after the input beat is
// accepted, and a new insert is taken every cycle while the output side keeps up.
// Drain of n entries: a setup step, then one entry beat per cycle while the output side
// keeps up; the input is stalled for the whole drain. An empty drain answers like an insert.
// The rate is set by the cell chain, which shifts by one cell per cycle while draining and not stalled.
// Reset (synchronous, active low) empties the table and sets keep_count to 32.
module top_k_value_tracker_core #(
    parameter int CAPACITY = tkvt_pkg::TKVT_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tkvt_pkg::t_in_beat                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tkvt_pkg::t_out_beat               o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tkvt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tkvt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tkvt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tkvt_pkg::*;

    // Width of the entry count, and a width that holds both the count and keep_count.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_total, n_total;
    logic                r_out_valid, n_out_valid;
    t_out_beat           r_out, n_out;
    logic [KEEP_W-1:0]   r_keep, n_keep;

    t_entry              w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_below;
    logic [CAPACITY-1:0] w_valid;
    t_cell_cmd           w_cmd;

    logic                w_out_free;
    logic                w_in_accept;
    logic                w_cfg_write;
    logic [CW-1:0]       w_count_ext;
    logic [CW-1:0]       w_keep_ext;
    logic [CW-1:0]       w_limit;
    logic                w_take;
    logic                w_evict;
    logic [CNT_W-1:0]    w_count_after;
    logic [CW-1:0]       w_held_ext;
    logic [CW-1:0]       w_total_ext;

    // The configuration port answers at once. Only keep_count exists; any address
    // whose register index is not keep_count is ignored on write and reads as zero.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[APB_ADDR_W-1:2] == REG_KEEP_COUNT) ?
                         APB_DATA_W'(r_keep) : '0;

    // A result beat waits in the output register; it can take a new beat when it is
    // empty or its beat leaves this cycle. Items are refused while a drain is running.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Effective limit: keep_count clamped to the range one to CAPACITY.
    assign w_count_ext = CW'(r_count);
    assign w_keep_ext  = CW'(r_keep);
    always_comb begin
        if (w_keep_ext == '0) begin
            w_limit = CW'(1);
        end else if (w_keep_ext > CW'(CAPACITY)) begin
            w_limit = CW'(CAPACITY);
        end else begin
            w_limit = w_keep_ext;
        end
    end

    // An insert is taken into an empty table, into a table below its limit, or when
    // it beats the smallest held value. A taken insert into a table at or above its
    // limit pushes the smallest entry out, so the table keeps its size.
    assign w_take  = (r_count == '0) || w_below[0] || (w_count_ext < w_limit);
    assign w_evict = (w_count_ext >= w_limit);
    assign w_count_after = (w_take && !w_evict) ? (r_count + CNT_W'(1)) : r_count;
    assign w_held_ext    = CW'(w_count_after);
    assign w_total_ext   = CW'(r_total);

    // Command broadcast to every cell.
    always_comb begin
        w_cmd.mode       = CM_HOLD;
        w_cmd.item.value = i_in_data.item_value;
        w_cmd.item.tag   = i_in_data.item_tag;
        if (r_state == ST_IDLE) begin
            if (w_in_accept && (i_in_data.operation == OP_INSERT) && w_take) begin
                w_cmd.mode = w_evict ? CM_INSERT_EVICT : CM_INSERT;
            end
        end else if (w_out_free) begin
            w_cmd.mode = CM_SHIFT;
        end
    end

    // The chain of cells. Cell 0 holds the smallest value; the held entries always
    // fill cells 0 to count-1 in ascending order. Each cell sees the entry and the
    // compare flag of both neighbors. Past the low end the flag reads as set, so an
    // insert point of zero lands in cell 0; past the high end it reads as clear.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_below;
        logic   w_next_below;

        assign w_valid[gi] = (r_count > CNT_W'(gi));

        if (gi == 0) begin : g_low
            assign w_prev       = '0;
            assign w_prev_below = 1'b1;
        end else begin : g_mid_low
            assign w_prev       = w_entry[gi-1];
            assign w_prev_below = w_below[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_high
            assign w_next       = '0;
            assign w_next_below = 1'b0;
        end else begin : g_mid_high
            assign w_next       = w_entry[gi+1];
            assign w_next_below = w_below[gi+1];
        end

        tkvt_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_valid      (w_valid[gi]),
            .i_prev_entry (w_prev),
            .i_prev_below (w_prev_below),
            .i_next_entry (w_next),
            .i_next_below (w_next_below),
            .o_entry      (w_entry[gi]),
            .o_below      (w_below[gi])
        );
    end

    // Sequencer: inserts finish in the idle state. A drain of a filled table moves to
    // the drain state, where cell 0 is sent out and the chain shifts down by one for
    // every beat the output register takes. The count falls with each beat, and the
    // beat that takes it to zero carries the last mark and ends the drain.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_keep      = r_keep;

        if (w_cfg_write && (paddr[APB_ADDR_W-1:2] == REG_KEEP_COUNT)) begin
            n_keep = pwdata[KEEP_W-1:0];
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_out_valid       = 1'b1;
                    n_out.entry_value = '0;
                    n_out.entry_tag   = '0;
                    n_out.last        = 1'b1;
                    if (i_in_data.operation == OP_INSERT) begin
                        n_count          = w_count_after;
                        n_out.result_kind = KIND_STATUS;
                        n_out.accepted   = w_take;
                        n_out.held_count = w_held_ext[HELD_W-1:0];
                    end else if (r_count == '0) begin
                        n_out.result_kind = KIND_EMPTY;
                        n_out.accepted   = 1'b0;
                        n_out.held_count = '0;
                    end else begin
                        n_out_valid = r_out_valid && i_out_stall;
                        n_out       = r_out;
                        n_total     = r_count;
                        n_state     = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = KIND_ENTRY;
                    n_out.accepted    = 1'b0;
                    n_out.held_count  = w_total_ext[HELD_W-1:0];
                    n_out.entry_value = w_entry[0].value;
                    n_out.entry_tag   = w_entry[0].tag;
                    n_out.last        = (r_count == CNT_W'(1));
                    n_count           = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_keep      <= KEEP_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_keep      <= n_keep;
        end
        r_total <= n_total;
        r_out   <= n_out;
    end

    // The two lowest held entries are in ascending order.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_entry[0].value <= w_entry[1].value))
        else $error("cell chain lost ascending order");

    // The table never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A running drain always has an entry left to send.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_count != '0))
        else $error("drain running on an empty table");

endmodule
